// ===== hw/rtl/spsg_pkg.sv =====
// Shared constants and types for the speed spike glitch detector.
`default_nettype none

package spsg_pkg;

  localparam int unsigned WIN_LEN_DEFAULT = 10;
  localparam int unsigned SPEED_W         = 8;
  localparam int unsigned POS_W           = 6;

  localparam logic [SPEED_W-1:0] SPEED_INVALID   = 8'hFF;
  localparam logic [SPEED_W-1:0] MIN_START       = 8'd200;
  localparam logic [SPEED_W-1:0] THRESHOLD_RESET = 8'd37;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_DONE
  } scan_state_t;

  typedef struct packed {
    logic               unstable;
    logic [SPEED_W-1:0] max_speed;
    logic [POS_W-1:0]   max_position;
    logic [SPEED_W-1:0] min_speed;
  } spsg_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spsg_mem.sv =====
// Sample window memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module spsg_mem
  import spsg_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = WIN_LEN_DEFAULT,
  localparam int unsigned AW = $clog2(WINDOW_LENGTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [SPEED_W-1:0] wr_data,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [SPEED_W-1:0] rd_speed
);

  logic [SPEED_W-1:0]       mem [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] vld_r;
  logic [SPEED_W-1:0]       rd_data_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Entries never written read back as invalid samples.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_speed = rd_vld_r ? rd_data_r : SPEED_INVALID;

endmodule

`default_nettype wire

// ===== hw/rtl/spsg_scan.sv =====
// Scan sequencer: stores the new sample and walks the window oldest to newest.
`default_nettype none

module spsg_scan
  import spsg_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = WIN_LEN_DEFAULT,
  localparam int unsigned AW = $clog2(WINDOW_LENGTH),
  localparam int unsigned CW = $clog2(WINDOW_LENGTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [SPEED_W-1:0] in_speed,
  output logic                    in_stall,
  input  wire logic [SPEED_W-1:0] threshold,
  output logic                    mem_wr_en,
  output logic      [AW-1:0]      mem_wr_addr,
  output logic      [SPEED_W-1:0] mem_wr_data,
  output logic      [AW-1:0]      mem_rd_addr,
  input  wire logic [SPEED_W-1:0] mem_rd_speed,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output spsg_res_t               res
);

  localparam logic [AW-1:0]    LAST_ADDR = AW'(WINDOW_LENGTH - 1);
  localparam logic [CW-1:0]    CNT_END   = CW'(WINDOW_LENGTH);
  localparam logic [POS_W-1:0] NEWEST    = POS_W'(WINDOW_LENGTH - 1);

  scan_state_t        state_r, state_nxt;
  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [CW-1:0]      cnt_r;
  logic [SPEED_W-1:0] lo_r, hi_r;
  logic [POS_W-1:0]   pos_r;
  logic               bad_r;

  logic               accept;
  logic               issue;
  logic               process_smp;
  logic [POS_W-1:0]   idx;
  logic [SPEED_W-1:0] lo_nxt, hi_nxt;
  logic [POS_W-1:0]   pos_nxt;
  logic               bad_nxt;
  logic               jump;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SCAN_IDLE: if (in_valid)          state_nxt = SCAN_RUN;
      SCAN_RUN:  if (cnt_r == CNT_END)  state_nxt = SCAN_DONE;
      SCAN_DONE: if (res_ready)         state_nxt = SCAN_IDLE;
      default:                          state_nxt = SCAN_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = 1'b1;
    res_valid = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      SCAN_IDLE: in_stall  = 1'b0;
      SCAN_RUN:  issue     = (cnt_r != CNT_END);
      SCAN_DONE: res_valid = 1'b1;
      default:   in_stall  = 1'b1;
    endcase
  end

  assign accept      = in_valid && !in_stall;
  assign process_smp = (state_r == SCAN_RUN) && (cnt_r != '0) && !bad_r;
  assign idx         = POS_W'(cnt_r - CW'(1));

  assign mem_wr_en   = accept;
  assign mem_wr_addr = wp_r;
  assign mem_wr_data = in_speed;
  assign mem_rd_addr = rd_ptr_r;

  // One window entry per cycle: track minimum, last maximum after it, stop on invalid.
  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    pos_nxt = pos_r;
    bad_nxt = bad_r;
    if (mem_rd_speed == SPEED_INVALID) begin
      hi_nxt  = SPEED_INVALID;
      bad_nxt = 1'b1;
    end else begin
      if (mem_rd_speed <= lo_r) begin
        lo_nxt  = mem_rd_speed;
        hi_nxt  = '0;
        pos_nxt = '0;
      end
      if (mem_rd_speed >= hi_nxt) begin
        hi_nxt  = mem_rd_speed;
        pos_nxt = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_IDLE;
      wp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        wp_r  <= ptr_inc(wp_r);
        cnt_r <= '0;
      end else if (state_r == SCAN_RUN && cnt_r != CNT_END) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ptr_r <= ptr_inc(wp_r);
      lo_r     <= MIN_START;
      hi_r     <= '0;
      pos_r    <= '0;
      bad_r    <= 1'b0;
    end else begin
      if (issue) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (process_smp) begin
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
        pos_r <= pos_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

  assign jump = (hi_r >= lo_r) && ((hi_r - lo_r) >= threshold) && (pos_r == NEWEST);

  always_comb begin
    res.unstable     = bad_r || jump;
    res.max_speed    = hi_r;
    res.max_position = pos_r;
    res.min_speed    = lo_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/speed_spike_glitch_detector_top.sv =====
// Speed spike glitch detector: sliding window of speed samples with jump check.
//
// Input channel: in_valid / in_stall carry one speed sample per request;
// 255 marks an invalid sample. Result channel: out_valid / out_stall carry
// one result per request (unstable flag, maximum, its position, minimum).
// Config channel: cfg_valid / cfg_ready write jump_threshold; write it only
// while no request is in flight. cfg_ready is always high.
//
// From acceptance, the scan walks the window and hands its result to the
// result register: the window memory has one read port with a registered
// output, so the scan reads one entry per cycle.
// The next sample is accepted once the scan has handed its result over, so
// a new request is not accepted while the last one is still in the scan.
// Reset clears the window to invalid samples through per-entry valid bits,
// so the first WINDOW_LENGTH-1 results flag unstable; threshold resets to 37.
// A stalled result is held in the output register; the scan of the next
// request may run meanwhile and then waits until the register frees up.
`default_nettype none

module speed_spike_glitch_detector_top
  import spsg_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = WIN_LEN_DEFAULT,
  localparam int unsigned AW = $clog2(WINDOW_LENGTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SPEED_W-1:0] in_speed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_unstable,
  output logic      [SPEED_W-1:0] out_max_speed,
  output logic      [POS_W-1:0]   out_max_position,
  output logic      [SPEED_W-1:0] out_min_speed,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [SPEED_W-1:0] cfg_jump_threshold
);

  logic [SPEED_W-1:0] threshold_r;
  logic               out_valid_r;
  spsg_res_t          out_r;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [SPEED_W-1:0] mem_wr_data;
  logic [AW-1:0]      mem_rd_addr;
  logic [SPEED_W-1:0] mem_rd_speed;
  logic               res_valid;
  logic               res_ready;
  spsg_res_t          res;

  spsg_mem #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .rd_addr  (mem_rd_addr),
    .rd_speed (mem_rd_speed)
  );

  spsg_scan #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_speed     (in_speed),
    .in_stall     (in_stall),
    .threshold    (threshold_r),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_speed (mem_rd_speed),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_jump_threshold;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  // Load a finished result whenever the output register is free or drains.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_unstable     = out_r.unstable;
  assign out_max_speed    = out_r.max_speed;
  assign out_max_position = out_r.max_position;
  assign out_min_speed    = out_r.min_speed;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again while a scan was starting");

  a_invalid_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.max_speed == SPEED_INVALID) |-> res.unstable)
    else $error("invalid sample met without unstable flag");

  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.min_speed <= MIN_START))
    else $error("window minimum above start value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
